/* hdl/page_frame_allocator_top_macros.svh */
// assertion helpers shared by the allocator rtl
`ifndef PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_TOP_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define PFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Request and response types, action and status codes for the page frame
// allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // request actions
  localparam logic [1:0] ACT_MAP   = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // response status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOMEM     = 2'd1;
  localparam logic [1:0] ST_UNALIGNED = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // configuration register index
  localparam logic REG_PAGE_LIMIT = 1'b0;

  localparam int unsigned LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] byte_address;
    logic [24:0] byte_length;
    logic        mark_used;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] alloc_address;
  } rsp_t;

endpackage

/* hdl/page_frame_allocator_top.sv */
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// First-fit contiguous page frame allocator over a one-bit-per-page bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_ready carry one request (map, allocate, free); every
//   request gives exactly one response on rsp/rsp_valid/rsp_ready.
//   The APB port holds page_limit at byte address 0; write it only while
//   no request is in flight.
//   A request is taken only in the idle state, so one request is worked at a
//   time. Each request walks the bitmap one page per cycle through a single
//   memory port pair and shared incrementers and comparators. Map and free
//   step through the requested pages below the limit; allocate scans from
//   page one until a run is found or the limit is reached, then marks the
//   found run. Error cases go straight to the response.
//   After reset a fill pass writes every page as used, during which
//   req_ready stays low (APB writes are still taken).
//   The response sits in an output register; a stalled receiver holds the
//   finished result, and the next request may already be taken, but its
//   response waits until the register drains.
// ----------------------------------------------------------------------------
`include "page_frame_allocator_top_macros.svh"

module page_frame_allocator_top
  import pfa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = 4096,
  parameter int unsigned PAGE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  localparam int unsigned IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned AW    = 26;
  localparam int unsigned PAGE_M1 = (1 << PAGE_BITS) - 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MAP, S_FREE, S_SCAN, S_MARK, S_RESP
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] clr_idx;
  logic [AW-1:0]    cur;
  logic [AW-1:0]    last;
  logic [AW-1:0]    need;
  logic [AW-1:0]    run;
  logic [AW-1:0]    start;
  logic             chk_vld;
  logic [AW-1:0]    chk_page;
  logic             fill;
  logic [1:0]       res_status;
  logic [23:0]      res_addr;
  logic [LIMIT_W-1:0] page_limit;

  logic [AW-1:0]    lim;
  logic [AW-1:0]    first_page;
  logic [AW-1:0]    map_count;
  logic [AW-1:0]    free_count;
  logic             misaligned;
  logic [AW-1:0]    cur_inc;
  logic [AW-1:0]    run_inc;
  logic             cur_in_lim;
  logic             found;
  logic [AW-1:0]    start_fin;
  logic             rsp_free;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_rdata;

  // apb register access
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAGE_LIMIT) begin
      prdata = {{(32-LIMIT_W){1'b0}}, page_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PAGE_LIMIT) begin
      page_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // effective limit and request decode
  always_comb begin
    lim = (AW'(page_limit) < AW'(PAGE_COUNT)) ? AW'(page_limit) : AW'(PAGE_COUNT);
    first_page = AW'(req.byte_address) >> PAGE_BITS;
    map_count  = AW'(req.byte_length) >> PAGE_BITS;
    free_count = (AW'(req.byte_length) + AW'(PAGE_M1)) >> PAGE_BITS;
    misaligned = (req.byte_address & 24'(PAGE_M1)) != 24'd0;
  end

  // shared incrementers and run compare
  always_comb begin
    cur_inc    = cur + AW'(1);
    run_inc    = run + AW'(1);
    cur_in_lim = cur < lim;
    found      = chk_vld && !mem_rdata && (run_inc == need);
    start_fin  = (run == '0) ? chk_page : start;
    rsp_free   = !rsp_valid || rsp_ready;
  end

  assign req_ready = (state == S_IDLE);

  // bitmap write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur[IDX_W-1:0];
    mem_wdata = 1'b1;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      S_MAP: begin
        mem_we    = (need != '0) && cur_in_lim;
        mem_wdata = fill;
      end
      S_FREE: begin
        mem_we    = (need != '0) && cur_in_lim;
        mem_wdata = 1'b0;
      end
      S_MARK: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pfa_bitmap_ram #(
    .DEPTH (PAGE_COUNT),
    .ADDR_W(IDX_W)
  ) u_bitmap (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(cur[IDX_W-1:0]),
    .rdata(mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        // fill every page as used after reset
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(PAGE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        // take a request
        S_IDLE: begin
          if (req_valid) begin
            res_addr   <= '0;
            fill       <= req.mark_used;
            chk_vld    <= 1'b0;
            run        <= '0;
            unique case (req.action)
              ACT_MAP: begin
                res_status <= ST_OK;
                cur        <= first_page;
                need       <= map_count;
                state      <= S_MAP;
              end
              ACT_ALLOC: begin
                need <= free_count;
                cur  <= AW'(1);
                if (free_count == '0) begin
                  res_status <= ST_NOMEM;
                  state      <= S_RESP;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
              ACT_FREE: begin
                cur  <= first_page;
                need <= free_count;
                if (misaligned) begin
                  res_status <= ST_UNALIGNED;
                  state      <= S_RESP;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_FREE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_RESP;
              end
            endcase
          end
        end
        // set or clear a range, pages past the limit are skipped
        S_MAP: begin
          if (need == '0 || !cur_in_lim) begin
            state <= S_RESP;
          end else begin
            cur  <= cur_inc;
            need <= need - AW'(1);
          end
        end
        // release pages, stop at the limit
        S_FREE: begin
          if (need == '0) begin
            state <= S_RESP;
          end else if (!cur_in_lim) begin
            res_status <= ST_RANGE;
            state      <= S_RESP;
          end else begin
            cur  <= cur_inc;
            need <= need - AW'(1);
          end
        end
        // first-fit scan, read issued the cycle before its check
        S_SCAN: begin
          chk_vld  <= cur_in_lim;
          chk_page <= cur;
          if (found) begin
            cur      <= start_fin;
            last     <= chk_page;
            res_addr <= 24'(start_fin << PAGE_BITS);
            state    <= S_MARK;
          end else begin
            if (cur_in_lim) begin
              cur <= cur_inc;
            end
            if (chk_vld) begin
              if (mem_rdata) begin
                run <= '0;
              end else begin
                run <= run_inc;
                if (run == '0) begin
                  start <= chk_page;
                end
              end
            end else if (!cur_in_lim) begin
              res_status <= ST_NOMEM;
              state      <= S_RESP;
            end
          end
        end
        // mark the found run used
        S_MARK: begin
          if (cur == last) begin
            state <= S_RESP;
          end else begin
            cur <= cur_inc;
          end
        end
        // hand the result to the output register
        S_RESP: begin
          if (rsp_free) begin
            rsp.status        <= res_status;
            rsp.alloc_address <= res_addr;
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `PFA_ASSERT_SAME(a_addr_only_ok, rsp_valid && rsp.alloc_address != 24'd0,
    rsp.status == ST_OK, "allocated address with failing status")
  `PFA_ASSERT_SAME(a_write_in_limit, mem_we && state != S_CLEAR, cur < lim,
    "bitmap write at or above the page limit")
  `PFA_ASSERT_SAME(a_run_below_need, state == S_SCAN, run < need,
    "free run count reached the request size without completing")
  `PFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready,
    "request taken while previous one still in work")

endmodule

/* hdl/pfa_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// pfa_bitmap_ram
// One bit per page: simple dual-port memory, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module pfa_bitmap_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page frame allocator: a bitmap shadow predicts
// every response, random bursts idle both channels, and page_limit is swept
// over small, zero, reset and saturating values between request phases.
// ----------------------------------------------------------------------------
module tb_top;
  import pfa_pkg::*;

  localparam int unsigned FRAMES     = 4096;
  localparam int unsigned FRAME_BITS = 12;
  localparam int unsigned FRAME_SIZE = 1 << FRAME_BITS;
  localparam int unsigned WATCHDOG_CYCLES = 60000;

  // apb byte addresses: page_limit, and one past it that must be ignored
  localparam logic [2:0] LIMIT_ADDR = {REG_PAGE_LIMIT, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_ready;
  req_t        req_bus;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp_bus;

  typedef struct {
    logic [23:0] addr;
    logic [24:0] len;
  } grant_t;

  // shadow bitmap and register, pending responses, live allocations
  bit          frame_used [FRAMES];
  logic [12:0] limit_shadow;
  rsp_t        pending_rsps[$];
  grant_t      live_grants[$];

  int unsigned errors;
  int unsigned reqs_sent;
  int unsigned rsps_checked;
  int unsigned cfg_writes;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idle_on;

  page_frame_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_bus),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp_bus)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // allocator shadow
  // ---------------------------------------------------------------------------

  function automatic int unsigned frames_in_play();
    return (limit_shadow < FRAMES) ? int'(limit_shadow) : FRAMES;
  endfunction

  function automatic rsp_t bitmap_response(req_t r);
    rsp_t        o;
    int unsigned lim, first, stop, need, start, run, p, q, base;
    bit          done;
    o.status = ST_OK;
    o.alloc_address = '0;
    lim = frames_in_play();
    start = 0;
    case (r.action)
      ACT_MAP: begin
        first = r.byte_address >> FRAME_BITS;
        stop = first + (r.byte_length >> FRAME_BITS);
        if (stop > lim) stop = lim;
        for (p = first; p < stop; p++) frame_used[p] = r.mark_used;
      end
      ACT_ALLOC: begin
        need = (32'(r.byte_length) + FRAME_SIZE - 1) >> FRAME_BITS;
        o.status = ST_NOMEM;
        if (need != 0) begin
          run = 0;
          done = 1'b0;
          // first fit, page zero never handed out
          for (p = 1; p < lim && !done; p++) begin
            if (!frame_used[p]) begin
              if (run == 0) start = p;
              run++;
              if (run == need) begin
                for (q = start; q <= p; q++) frame_used[q] = 1'b1;
                o.alloc_address = 24'(start << FRAME_BITS);
                o.status = ST_OK;
                done = 1'b1;
              end
            end else begin
              run = 0;
            end
          end
        end
      end
      ACT_FREE: begin
        if (r.byte_address[FRAME_BITS-1:0] != '0) begin
          o.status = ST_UNALIGNED;
        end else begin
          base = r.byte_address >> FRAME_BITS;
          need = (32'(r.byte_length) + FRAME_SIZE - 1) >> FRAME_BITS;
          done = 1'b0;
          for (p = 0; p < need && !done; p++) begin
            if (base + p >= lim) begin
              o.status = ST_RANGE;
              done = 1'b1;
            end else begin
              frame_used[base + p] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] act, logic [23:0] addr,
                                    logic [24:0] len, logic mark);
    req_t r;
    r.action = act;
    r.byte_address = addr;
    r.byte_length = len;
    r.mark_used = mark;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request transfer; called and returns at a falling edge
  task automatic send_req(req_t r);
    rsp_t   o;
    grant_t g;
    req_bus = r;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    o = bitmap_response(r);
    pending_rsps.push_back(o);
    reqs_sent++;
    if (r.action == ACT_ALLOC && o.status == ST_OK) begin
      g.addr = o.alloc_address;
      g.len = r.byte_length;
      live_grants.push_back(g);
    end
    @(negedge clk);
    // random gap after the transfer
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    req_valid = 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
  endtask

  // apb write, block idle
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    wait_drain();
    repeat (8) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == LIMIT_ADDR) limit_shadow = data[12:0];
    cfg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    live_grants.delete();
  endtask

  task automatic set_limit(int unsigned lim);
    cfg_write(LIMIT_ADDR, 32'(lim));
  endtask

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_ready = 1'b0;
      stall_left--;
    end else begin
      rsp_ready = 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  // ---------------------------------------------------------------------------
  // response checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsps.size() == 0) begin
        errors++;
        $display("%0t: response with none pending: expected none, actual status %0d addr %h",
                 $time, rsp_bus.status, rsp_bus.alloc_address);
      end else begin
        want = pending_rsps.pop_front();
        rsps_checked++;
        if (rsp_bus.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp_bus.status);
        end
        if (rsp_bus.alloc_address !== want.alloc_address) begin
          errors++;
          $display("%0t: alloc_address mismatch: expected %h actual %h",
                   $time, want.alloc_address, rsp_bus.alloc_address);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: watchdog expired, %0d responses pending", $time,
                 pending_rsps.size());
        $display("page_frame_allocator_top verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // edge cases at the reset limit, bitmap starts all used
  task automatic test_directed();
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd4096, 1'b0));       // nothing free
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd0, 1'b0));          // zero length
    send_req(make_req(ACT_MAP, 24'h0, 25'(16 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_ALLOC, 24'hFFFFFF, 25'd1, 1'b1));     // page one
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(3 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(FRAME_SIZE + 1), 1'b0));
    send_req(make_req(ACT_FREE, 24'h001001, 25'd4096, 1'b0));   // unaligned
    send_req(make_req(ACT_FREE, 24'h001FFF, 25'd4096, 1'b0));
    send_req(make_req(ACT_FREE, 24'h001000, 25'd0, 1'b0));      // zero length
    send_req(make_req(ACT_FREE, 24'h002000, 25'(3 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_FREE, 24'h002000, 25'(3 * FRAME_SIZE), 1'b0)); // again
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(2 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_FREE, 24'hFFF000, 25'(2 * FRAME_SIZE), 1'b0)); // at limit
    send_req(make_req(ACT_FREE, 24'hFFF000, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd4096, 1'b0));
    send_req(make_req(ACT_MAP, 24'hFF0000, 25'h1000000, 1'b1)); // past limit
    send_req(make_req(ACT_MAP, 24'hFFFFFF, 25'h1FFFFFF, 1'b0));
    send_req(make_req(2'd3, 24'hFFFFFF, 25'h1FFFFFF, 1'b1));    // action three
    send_req(make_req(ACT_ALLOC, 24'h0, 25'h1000000, 1'b0));    // too large
    send_req(make_req(ACT_MAP, 24'h000000, 25'h0000FFF, 1'b0)); // under a page
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(12 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd1, 1'b0));
  endtask

  // zero, one page, saturated limit and the ignored register
  task automatic test_limit_extremes();
    set_limit(0);
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd1, 1'b0));
    send_req(make_req(ACT_FREE, 24'h0, 25'd1, 1'b0));
    set_limit(1);
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd1, 1'b0));
    send_req(make_req(ACT_FREE, 24'h0, 25'(2 * FRAME_SIZE), 1'b0));
    set_limit(13'h1FFF);
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b1));
    send_req(make_req(ACT_MAP, 24'h000000, 25'(8 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(7 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_FREE, 24'hFFE000, 25'h1000000, 1'b0));
    set_limit(2);
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd4096, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd1, 1'b0));
  endtask

  // mostly map/alloc/free sequences inside the limit, some noise
  task automatic run_random(int unsigned count);
    int unsigned lim, kind, page, idx;
    logic [23:0] addr;
    logic [24:0] len;
    grant_t      g;
    lim = frames_in_play();
    repeat (count) begin
      kind = $urandom_range(0, 9);
      page = $urandom_range(0, lim + 2);
      if (page >= FRAMES) page = FRAMES - 1;
      addr = 24'(page << FRAME_BITS);
      case (kind) inside
        [0:1]: begin
          len = 25'($urandom_range(0, lim / 2 + 2) * FRAME_SIZE + $urandom_range(0, 4095));
          send_req(make_req(ACT_MAP, addr, len, $urandom_range(0, 4) == 0));
        end
        [2:5]: begin
          len = 25'($urandom_range(0, (lim / 4 + 2) * FRAME_SIZE));
          send_req(make_req(ACT_ALLOC, 24'($urandom), len, 1'($urandom)));
        end
        [6:7]: begin
          if (live_grants.size() != 0) begin
            idx = $urandom_range(0, live_grants.size() - 1);
            g = live_grants[idx];
            live_grants.delete(idx);
            send_req(make_req(ACT_FREE, g.addr, g.len, 1'($urandom)));
          end else begin
            len = 25'($urandom_range(0, 4 * FRAME_SIZE));
            send_req(make_req(ACT_FREE, addr, len, 1'($urandom)));
          end
        end
        8: begin
          if ($urandom_range(0, 1) == 0) addr = addr | 24'($urandom_range(1, 4095));
          len = 25'($urandom_range(0, (lim + 4) * FRAME_SIZE));
          send_req(make_req(ACT_FREE, addr, len, 1'($urandom)));
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? 25'h1000000 : 25'($urandom);
          send_req(make_req(2'($urandom_range(0, 3)), 24'($urandom), len, 1'($urandom)));
        end
      endcase
    end
  endtask

  task automatic test_random_small();
    set_limit(64);
    run_random(18);
    set_limit(2);
    run_random(8);
    set_limit(37);
    run_random(19);
    set_limit(100);
    run_random(19);
  endtask

  // sender holds off until every response is back, then resumes
  task automatic test_drain_pause();
    set_limit(48);
    send_req(make_req(ACT_MAP, 24'h0, 25'(48 * FRAME_SIZE), 1'b0));
    run_random(6);
    wait_drain();
    repeat ($urandom_range(1, 17)) @(negedge clk);
    run_random(6);
  endtask

  // a few full size requests at the widest limit
  task automatic test_large();
    set_limit(4096);
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'(4095 * FRAME_SIZE), 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'd1, 1'b0));
    send_req(make_req(ACT_FREE, 24'h001000, 25'h1000000, 1'b0));
    send_req(make_req(ACT_ALLOC, 24'h0, 25'($urandom_range(1, 24'hFFFFFF)), 1'b0));
    send_req(make_req(ACT_MAP, 24'h0, 25'h1000000, 1'b1));
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    set_limit(200);
    wait_drain();
    idle_on = 1'b0;
    stall_left = 0;
    send_req(make_req(ACT_MAP, 24'h0, 25'(200 * FRAME_SIZE), 1'b0));
    run_random(20);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req_bus = '0;
    rsp_ready = 1'b0;
    errors = 0;
    reqs_sent = 0;
    rsps_checked = 0;
    cfg_writes = 0;
    quiet_cycles = 0;
    stall_left = 0;
    idle_on = 1'b1;
    limit_shadow = LIMIT_RESET;
    foreach (frame_used[i]) frame_used[i] = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_limit_extremes();
    test_random_small();
    test_drain_pause();
    test_large();
    test_back_to_back();

    wait_drain();
    repeat (50) @(negedge clk);
    if (pending_rsps.size() != 0) errors++;
    $display("covered %0d requests and %0d responses across %0d register writes",
             reqs_sent, rsps_checked, cfg_writes);
    $display("limits from zero to saturated, first-fit allocate, map and free edges");
    if (errors == 0) begin
      $display("page_frame_allocator_top verification clean");
    end else begin
      $display("page_frame_allocator_top verification failed");
    end
    $finish;
  end

endmodule

/* page_frame_allocator_top.f */
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_bitmap_ram.sv
hdl/page_frame_allocator_top.sv
sim/tb_top.sv
